// ===== rtl/atw_pkg.sv =====
// shared constants, types and the arctangent table of the tilt window average block
package atw_pkg;

    // field widths and sizing
    localparam int IN_W        = 16;
    localparam int ANGLE_W     = 16;
    localparam int WINDOW      = 200;
    localparam int SAMPLE_BITS = 16;
    localparam int PRE_SHIFT   = 8;
    localparam int ITERS       = 17;
    localparam int ITER_W      = $clog2(ITERS);
    localparam int PI_Q16      = 205887;
    localparam int PI_Q13      = 25736;

    // cordic vector and angle accumulator widths (gain and pi headroom)
    localparam int XY_W = SAMPLE_BITS + PRE_SHIFT + 3;
    localparam int Z_W  = 21;

    // ring and running sum
    localparam int PTR_W = $clog2(WINDOW);
    localparam int SUM_W = $clog2(WINDOW * PI_Q13 + 1) + 1;

    // rounded mean: (|sum| + WINDOW/2) * RECIP >> RECIP_K equals the floor divide
    localparam int NUM_W   = $clog2(WINDOW * PI_Q13 + WINDOW / 2 + 1);
    localparam int RECIP_K = NUM_W + $clog2(WINDOW);
    localparam int RECIP_W = NUM_W + 1;
    localparam longint unsigned RECIP = ((64'd1 << RECIP_K) + WINDOW - 1) / WINDOW;
    localparam int PROD_W  = NUM_W + RECIP_W;
    localparam int Q_W     = ANGLE_W - 1;

    // controller states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ITER,
        ST_ROUND,
        ST_ACCUM,
        ST_SCALE,
        ST_MULT,
        ST_EMIT
    } state_t;

    // commands from controller to datapath
    typedef struct packed {
        logic              load;
        logic              iter;
        logic [ITER_W-1:0] iter_idx;
        logic              round;
        logic              accum;
        logic              scale;
        logic              mult;
        logic              emit;
    } cmd_t;

    // status from datapath to controller
    typedef struct packed {
        logic out_busy;
    } status_t;

    // atan(2^-i) in Q.16, rounded to nearest
    function automatic logic signed [Z_W-1:0] atan_q16(input logic [ITER_W-1:0] idx);
        logic signed [Z_W-1:0] val;
        unique case (idx)
            ITER_W'(0):  val = Z_W'(51472);
            ITER_W'(1):  val = Z_W'(30386);
            ITER_W'(2):  val = Z_W'(16055);
            ITER_W'(3):  val = Z_W'(8150);
            ITER_W'(4):  val = Z_W'(4091);
            ITER_W'(5):  val = Z_W'(2047);
            ITER_W'(6):  val = Z_W'(1024);
            ITER_W'(7):  val = Z_W'(512);
            ITER_W'(8):  val = Z_W'(256);
            ITER_W'(9):  val = Z_W'(128);
            ITER_W'(10): val = Z_W'(64);
            ITER_W'(11): val = Z_W'(32);
            ITER_W'(12): val = Z_W'(16);
            ITER_W'(13): val = Z_W'(8);
            ITER_W'(14): val = Z_W'(4);
            ITER_W'(15): val = Z_W'(2);
            ITER_W'(16): val = Z_W'(1);
            default:     val = '0;
        endcase
        return val;
    endfunction

endpackage

// ===== rtl/atw_ram.sv =====
// generic single-port-write, single-port-read ram with registered read data
module atw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 200
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

// ===== rtl/atw_ctrl.sv =====
// controller state machine: sequences cordic iterations, ring update and mean scaling
module atw_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  atw_pkg::status_t status,
    output atw_pkg::cmd_t    cmd
);

    import atw_pkg::*;

    state_t            state_reg, state_next;
    logic [ITER_W-1:0] iter_reg, iter_next;
    logic              iter_last;

    assign iter_last = (iter_reg == ITER_W'(ITERS - 1));

    // state and iteration counter registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            iter_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            iter_reg  <= iter_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:  if (in_valid) state_next = ST_ITER;
            ST_ITER:  if (iter_last) state_next = ST_ROUND;
            ST_ROUND: state_next = ST_ACCUM;
            ST_ACCUM: state_next = ST_SCALE;
            ST_SCALE: state_next = ST_MULT;
            ST_MULT:  state_next = ST_EMIT;
            ST_EMIT:  if (!status.out_busy) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    // iteration counter
    always_comb
    begin
        iter_next = iter_reg;
        unique case (state_reg)
            ST_IDLE: iter_next = '0;
            ST_ITER: iter_next = iter_last ? '0 : iter_reg + ITER_W'(1);
            default: iter_next = iter_reg;
        endcase
    end

    // outputs
    always_comb
    begin
        cmd          = '0;
        cmd.iter_idx = iter_reg;
        in_ready     = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = in_valid;
            end
            ST_ITER:  cmd.iter  = 1'b1;
            ST_ROUND: cmd.round = 1'b1;
            ST_ACCUM: cmd.accum = 1'b1;
            ST_SCALE: cmd.scale = 1'b1;
            ST_MULT:  cmd.mult  = 1'b1;
            ST_EMIT:  cmd.emit  = !status.out_busy;
            default:  cmd = '0;
        endcase
    end

endmodule

// ===== rtl/atw_datapath.sv =====
// datapath: iterative cordic, angle ring with running sum, reciprocal scaling, output register
module atw_datapath (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [atw_pkg::IN_W-1:0]      accel_x,
    input  logic [atw_pkg::IN_W-1:0]      accel_y,
    input  atw_pkg::cmd_t                 cmd,
    output atw_pkg::status_t              status,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [atw_pkg::ANGLE_W-1:0]   mean_angle,
    output logic [atw_pkg::ANGLE_W-1:0]   instant_angle
);

    import atw_pkg::*;

    localparam logic signed [Z_W-1:0]   PI16_Z  = Z_W'(PI_Q16);
    localparam logic signed [Z_W-1:0]   PI13_Z  = Z_W'(PI_Q13);
    localparam logic signed [Z_W-1:0]   ROUND_Z = Z_W'(4);
    localparam logic [RECIP_W-1:0]      RECIP_C = RECIP_W'(RECIP);
    localparam logic [NUM_W-1:0]        HALF_W  = NUM_W'(WINDOW / 2);
    localparam logic signed [SUM_W-1:0] SUM_MAX = SUM_W'(WINDOW * PI_Q13);

    // cordic registers
    logic signed [XY_W-1:0]    x_reg, y_reg;
    logic signed [Z_W-1:0]     z_reg;
    logic                      zero_reg;

    // ring and sum registers
    logic signed [ANGLE_W-1:0] angle_reg, old_reg;
    logic signed [SUM_W-1:0]   sum_reg, sum_next;
    logic [PTR_W-1:0]          ptr_reg, ptr_next;
    logic [WINDOW-1:0]         valid_reg;
    logic [ANGLE_W-1:0]        ram_rdata;

    // scaling registers
    logic                      neg_reg;
    logic [NUM_W-1:0]          mag_reg;
    logic [PROD_W-1:0]         prod_reg;

    // output registers
    logic                      out_valid_reg;
    logic signed [ANGLE_W-1:0] out_mean_reg, out_inst_reg;

    // sample load: sign extend and pre-scale
    logic signed [XY_W-1:0]    x_in, y_in;
    logic                      zero_in;

    assign x_in = {{(XY_W - SAMPLE_BITS - PRE_SHIFT){accel_x[SAMPLE_BITS-1]}},
                   accel_x[SAMPLE_BITS-1:0], {PRE_SHIFT{1'b0}}};
    assign y_in = {{(XY_W - SAMPLE_BITS - PRE_SHIFT){accel_y[SAMPLE_BITS-1]}},
                   accel_y[SAMPLE_BITS-1:0], {PRE_SHIFT{1'b0}}};
    assign zero_in = (accel_x[SAMPLE_BITS-1:0] == '0) && (accel_y[SAMPLE_BITS-1:0] == '0);

    // one vectoring step
    logic signed [XY_W-1:0] dx, dy;
    logic signed [Z_W-1:0]  atan_val;

    assign dx       = y_reg >>> cmd.iter_idx;
    assign dy       = x_reg >>> cmd.iter_idx;
    assign atan_val = atan_q16(cmd.iter_idx);

    // final angle: round Q.16 to Q.13 and clamp to +-pi
    logic signed [Z_W-1:0]     z_rnd;
    logic signed [ANGLE_W-1:0] angle_clamped;

    always_comb
    begin
        z_rnd = (z_reg + ROUND_Z) >>> 3;
        priority if (z_rnd > PI13_Z)
        begin
            angle_clamped = ANGLE_W'(PI_Q13);
        end
        else if (z_rnd < -PI13_Z)
        begin
            angle_clamped = -ANGLE_W'(PI_Q13);
        end
        else
        begin
            angle_clamped = z_rnd[ANGLE_W-1:0];
        end
    end

    // ring of angles
    atw_ram #(
        .WIDTH (ANGLE_W),
        .DEPTH (WINDOW)
    ) u_ring (
        .clk   (clk),
        .we    (cmd.accum),
        .waddr (ptr_reg),
        .wdata (angle_reg),
        .raddr (ptr_reg),
        .rdata (ram_rdata)
    );

    // running sum and pointer update
    always_comb
    begin
        sum_next = sum_reg - SUM_W'(old_reg) + SUM_W'(angle_reg);
        ptr_next = (ptr_reg == PTR_W'(WINDOW - 1)) ? '0 : ptr_reg + PTR_W'(1);
    end

    // control state with reset: ring bookkeeping and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg       <= '0;
            ptr_reg       <= '0;
            valid_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.accum)
            begin
                sum_reg            <= sum_next;
                ptr_reg            <= ptr_next;
                valid_reg[ptr_reg] <= 1'b1;
            end
            if (cmd.emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        // load sample, fold left half-plane onto the right
        if (cmd.load)
        begin
            zero_reg <= zero_in;
            if (x_in < 0)
            begin
                x_reg <= -x_in;
                y_reg <= -y_in;
                z_reg <= (y_in >= 0) ? PI16_Z : -PI16_Z;
            end
            else
            begin
                x_reg <= x_in;
                y_reg <= y_in;
                z_reg <= '0;
            end
        end
        // rotate toward the x axis
        if (cmd.iter)
        begin
            if (y_reg >= 0)
            begin
                x_reg <= x_reg + dx;
                y_reg <= y_reg - dy;
                z_reg <= z_reg + atan_val;
            end
            else
            begin
                x_reg <= x_reg - dx;
                y_reg <= y_reg + dy;
                z_reg <= z_reg - atan_val;
            end
        end
        // settle angle and fetch the entry being replaced
        if (cmd.round)
        begin
            angle_reg <= zero_reg ? '0 : angle_clamped;
            old_reg   <= valid_reg[ptr_reg] ? ram_rdata : '0;
        end
        // magnitude plus half window for round-half-away
        if (cmd.scale)
        begin
            neg_reg <= sum_reg[SUM_W-1];
            mag_reg <= NUM_W'(sum_reg[SUM_W-1] ? -sum_reg : sum_reg) + HALF_W;
        end
        // multiply by reciprocal of window
        if (cmd.mult)
        begin
            prod_reg <= PROD_W'(mag_reg) * PROD_W'(RECIP_C);
        end
        // output beat
        if (cmd.emit)
        begin
            out_inst_reg <= angle_reg;
            out_mean_reg <= neg_reg ? -ANGLE_W'(prod_reg[RECIP_K +: Q_W])
                                    :  ANGLE_W'(prod_reg[RECIP_K +: Q_W]);
        end
    end

    assign status.out_busy = out_valid_reg && !out_ready;
    assign out_valid       = out_valid_reg;
    assign mean_angle      = out_mean_reg;
    assign instant_angle   = out_inst_reg;

`ifndef SYNTHESIS
    a_emit_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |=> out_valid_reg)
        else $error("output beat not presented after emit");

    a_emit_not_over_pending: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> !(out_valid_reg && !out_ready))
        else $error("emit overwrote a pending output beat");

    a_instant_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_inst_reg <= ANGLE_W'(PI_Q13)) &&
                          (out_inst_reg >= -ANGLE_W'(PI_Q13)))
        else $error("instant angle outside +-pi");

    a_sum_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        (sum_reg <= SUM_MAX) && (sum_reg >= -SUM_MAX))
        else $error("window sum outside its bound");
`endif

endmodule

// ===== rtl/accel_tilt_window_average_core.sv =====
// top level of the accelerometer tilt angle window average block
//
//  channel   | dir | beat payload
//  ----------+-----+---------------------------------------------
//  s_axis    | in  | tdata[15:0] accel_x, tdata[31:16] accel_y
//  m_axis    | out | tdata[15:0] mean_angle, tdata[31:16] instant_angle
//
// a sample goes from accept to the next possible accept through one load,
// seventeen iterations of the shared cordic stage, then round, ring update,
// magnitude, reciprocal multiply and output register, in that order.
// reset clears the ring through per-entry valid bits at once, no clearing pass.
// the result sits in an output register, so a stalled m_axis only holds the
// controller in its last step while the result waits; s_axis is ready in idle.
module accel_tilt_window_average_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [15:0] accel_x, [31:16] accel_y
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata    // [15:0] mean_angle, [31:16] instant_angle
);

    import atw_pkg::*;

    cmd_t                cmd;
    status_t             status;
    logic [ANGLE_W-1:0]  mean_angle, instant_angle;

    // sequencing
    atw_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .status   (status),
        .cmd      (cmd)
    );

    // arithmetic and storage
    atw_datapath u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .accel_x       (s_axis_tdata[IN_W-1:0]),
        .accel_y       (s_axis_tdata[2*IN_W-1:IN_W]),
        .cmd           (cmd),
        .status        (status),
        .out_valid     (m_axis_tvalid),
        .out_ready     (m_axis_tready),
        .mean_angle    (mean_angle),
        .instant_angle (instant_angle)
    );

    assign m_axis_tdata = {instant_angle, mean_angle};

endmodule
